[rtl/core/rrpc_pkg.sv]
// Shared types, codes and the control-store program for the rational-rate playhead clock.
// No dependencies; used by rational_rate_playhead_clock.
package rrpc_pkg;

  localparam int RATE_WIDTH_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int RATE_FIELD_W   = 16;

  // command opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_PAUSE   = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_SEEK    = 3'd3;
  localparam logic [2:0] OP_SPEED   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_CHANGED = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [TIME_W-1:0]       now;
    logic                    pause_flag;
    logic [TIME_W-1:0]       seek_ms;
    logic [RATE_FIELD_W-1:0] rate_num;
    logic [RATE_FIELD_W-1:0] rate_den;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] playhead_out;
    logic              is_paused;
    logic              is_completed;
  } res_t;

  // datapath micro-operations
  localparam logic [2:0] UOP_NONE      = 3'd0;
  localparam logic [2:0] UOP_SIMPLE    = 3'd1;
  localparam logic [2:0] UOP_TICK_PRE  = 3'd2;
  localparam logic [2:0] UOP_MUL       = 3'd3;
  localparam logic [2:0] UOP_ADD       = 3'd4;
  localparam logic [2:0] UOP_DIV       = 3'd5;
  localparam logic [2:0] UOP_TICK_POST = 3'd6;
  localparam logic [2:0] UOP_EMIT      = 3'd7;

  // jump conditions
  localparam logic [2:0] C_NEXT     = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_ITEM  = 3'd2;
  localparam logic [2:0] C_IS_TICK  = 3'd3;
  localparam logic [2:0] C_SKIP     = 3'd4;
  localparam logic [2:0] C_DIV_MORE = 3'd5;
  localparam logic [2:0] C_OUT_BUSY = 3'd6;

  // step addresses
  localparam int         UC_DEPTH    = 10;
  localparam logic [3:0] UC_IDLE     = 4'd0;
  localparam logic [3:0] UC_DISPATCH = 4'd1;
  localparam logic [3:0] UC_SIMPLE   = 4'd2;
  localparam logic [3:0] UC_PRE      = 4'd3;
  localparam logic [3:0] UC_MUL      = 4'd4;
  localparam logic [3:0] UC_ADD      = 4'd5;
  localparam logic [3:0] UC_DIV      = 4'd6;
  localparam logic [3:0] UC_POST     = 4'd7;
  localparam logic [3:0] UC_EMIT     = 4'd8;
  localparam logic [3:0] UC_RET      = 4'd9;

  typedef struct packed {
    logic [2:0] uop;
    logic [2:0] cond;
    logic [3:0] target;
  } ucw_t;

  localparam ucw_t UCODE [UC_DEPTH] = '{
    '{UOP_NONE,      C_NO_ITEM,  UC_IDLE},
    '{UOP_NONE,      C_IS_TICK,  UC_PRE},
    '{UOP_SIMPLE,    C_ALWAYS,   UC_EMIT},
    '{UOP_TICK_PRE,  C_NEXT,     UC_IDLE},
    '{UOP_MUL,       C_SKIP,     UC_EMIT},
    '{UOP_ADD,       C_NEXT,     UC_IDLE},
    '{UOP_DIV,       C_DIV_MORE, UC_DIV},
    '{UOP_TICK_POST, C_NEXT,     UC_IDLE},
    '{UOP_EMIT,      C_OUT_BUSY, UC_EMIT},
    '{UOP_NONE,      C_ALWAYS,   UC_IDLE}
  };

endpackage

[rtl/core/rational_rate_playhead_clock.sv]
// Playback clock top level: microcoded sequencer, datapath and output register.
// Depends on rrpc_pkg for payload types, codes and the control-store program.
//
// One command is taken at a time. Pause, restart, seek, set speed and unused opcodes
// go from the simple step straight to emit; a tick that ends early (zero duration,
// paused, no elapsed time, already at the end) skips from its multiply step to emit;
// a full tick runs add, divide and post before emit, using the restoring divider,
// which yields one quotient bit per cycle over the 32 + RATE_WIDTH bit scaled time.
// The result sits in an output register, so the next command is accepted while it
// waits; a later command stalls only at its emit step if that register is still full.
module rational_rate_playhead_clock #(
  parameter int RATE_WIDTH = rrpc_pkg::RATE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rrpc_pkg::cmd_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rrpc_pkg::res_t              out_data,
  input  logic                        cfg_we,
  input  logic [rrpc_pkg::TIME_W-1:0] cfg_data
);

  localparam int TW    = rrpc_pkg::TIME_W;
  localparam int SW    = TW + RATE_WIDTH;
  localparam int CNT_W = $clog2(SW);

  // sequencer
  logic [3:0]     upc;
  logic [3:0]     upc_next;
  rrpc_pkg::ucw_t ucw;
  logic           take_jump;

  // state
  logic [TW-1:0]         duration;
  logic [TW-1:0]         playhead;
  logic [RATE_WIDTH-1:0] carry;
  logic [TW-1:0]         last_time;
  logic                  paused;
  logic                  completed;
  logic [RATE_WIDTH-1:0] speed_num;
  logic [RATE_WIDTH-1:0] speed_den;

  // working registers
  rrpc_pkg::cmd_t        cmd;
  logic [1:0]            status;
  logic                  skip;
  logic [TW-1:0]         elapsed;
  logic [SW-1:0]         quo;
  logic [RATE_WIDTH-1:0] rem;
  logic [CNT_W-1:0]      cnt;

  // datapath combinational terms
  logic [TW-1:0]         elapsed_now;
  logic [RATE_WIDTH:0]   trial;
  logic                  trial_ge;
  logic [TW-1:0]         room;
  logic                  adv_fin;
  logic [TW-1:0]         target_cl;
  logic [RATE_WIDTH-1:0] num_in;
  logic [RATE_WIDTH-1:0] den_in;
  logic                  restart_chg;
  logic                  seek_chg;

  assign ucw      = rrpc_pkg::UCODE[upc];
  assign in_stall = (upc != rrpc_pkg::UC_IDLE);

  always_comb begin
    unique case (ucw.cond)
      rrpc_pkg::C_NEXT:     take_jump = 1'b0;
      rrpc_pkg::C_ALWAYS:   take_jump = 1'b1;
      rrpc_pkg::C_NO_ITEM:  take_jump = !in_valid;
      rrpc_pkg::C_IS_TICK:  take_jump = (cmd.opcode == rrpc_pkg::OP_TICK);
      rrpc_pkg::C_SKIP:     take_jump = skip;
      rrpc_pkg::C_DIV_MORE: take_jump = (cnt != '0);
      rrpc_pkg::C_OUT_BUSY: take_jump = out_valid && out_stall;
      default:              take_jump = 1'b0;
    endcase
    upc_next = take_jump ? ucw.target : upc + 4'd1;
  end

  assign elapsed_now = cmd.now - last_time;
  assign trial       = {rem, quo[SW-1]};
  assign trial_ge    = (trial >= {1'b0, speed_den});
  assign room        = duration - playhead;
  assign adv_fin     = (quo >= SW'(room));
  assign target_cl   = (cmd.seek_ms < duration) ? cmd.seek_ms : duration;
  assign num_in      = RATE_WIDTH'(cmd.rate_num);
  assign den_in      = RATE_WIDTH'(cmd.rate_den);
  assign restart_chg = (playhead != '0) || (carry != '0) || paused || completed;
  assign seek_chg    = (target_cl != playhead) || !paused || completed || (carry != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= rrpc_pkg::UC_IDLE;
      out_valid <= 1'b0;
      duration  <= '0;
      playhead  <= '0;
      carry     <= '0;
      last_time <= '0;
      paused    <= 1'b0;
      completed <= 1'b0;
      speed_num <= RATE_WIDTH'(1);
      speed_den <= RATE_WIDTH'(1);
      skip      <= 1'b0;
    end else begin
      upc <= upc_next;
      if (cfg_we) begin
        duration <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (upc == rrpc_pkg::UC_IDLE && in_valid) begin
        cmd <= in_data;
      end

      unique case (ucw.uop)
        rrpc_pkg::UOP_NONE: begin
        end
        rrpc_pkg::UOP_SIMPLE: begin
          status <= rrpc_pkg::ST_NONE;
          unique case (cmd.opcode)
            rrpc_pkg::OP_PAUSE: begin
              if (!(paused == cmd.pause_flag || (completed && !cmd.pause_flag))) begin
                paused    <= cmd.pause_flag;
                last_time <= cmd.now;
                carry     <= '0;
                status    <= rrpc_pkg::ST_CHANGED;
              end
            end
            rrpc_pkg::OP_RESTART: begin
              playhead  <= '0;
              carry     <= '0;
              paused    <= 1'b0;
              completed <= 1'b0;
              last_time <= cmd.now;
              status    <= restart_chg ? rrpc_pkg::ST_CHANGED : rrpc_pkg::ST_NONE;
            end
            rrpc_pkg::OP_SEEK: begin
              if (duration != '0) begin
                playhead  <= target_cl;
                last_time <= cmd.now;
                carry     <= '0;
                paused    <= 1'b1;
                completed <= (target_cl == duration);
                status    <= seek_chg ? rrpc_pkg::ST_CHANGED : rrpc_pkg::ST_NONE;
              end
            end
            rrpc_pkg::OP_SPEED: begin
              if (num_in != '0 && den_in != '0 &&
                  !(num_in == speed_num && den_in == speed_den)) begin
                speed_num <= num_in;
                speed_den <= den_in;
                last_time <= cmd.now;
                carry     <= '0;
                status    <= rrpc_pkg::ST_CHANGED;
              end
            end
            default: begin
            end
          endcase
        end
        rrpc_pkg::UOP_TICK_PRE: begin
          status <= rrpc_pkg::ST_NONE;
          skip   <= 1'b1;
          if (duration != '0) begin
            elapsed   <= elapsed_now;
            last_time <= cmd.now;
            if (paused || completed || elapsed_now == '0 || speed_den == '0) begin
              skip <= 1'b1;
            end else if (playhead >= duration) begin
              playhead  <= duration;
              carry     <= '0;
              paused    <= 1'b1;
              completed <= 1'b1;
              status    <= rrpc_pkg::ST_DONE;
            end else begin
              skip <= 1'b0;
            end
          end
        end
        rrpc_pkg::UOP_MUL: begin
          quo <= SW'(elapsed * speed_num);
        end
        rrpc_pkg::UOP_ADD: begin
          quo <= quo + SW'(carry);
          rem <= '0;
          cnt <= CNT_W'(SW - 1);
        end
        rrpc_pkg::UOP_DIV: begin
          // restoring step: remainder stays below the divisor
          rem <= trial_ge ? RATE_WIDTH'(trial - {1'b0, speed_den}) : trial[RATE_WIDTH-1:0];
          quo <= {quo[SW-2:0], trial_ge};
          cnt <= cnt - CNT_W'(1);
        end
        rrpc_pkg::UOP_TICK_POST: begin
          if (adv_fin) begin
            playhead  <= duration;
            carry     <= '0;
            paused    <= 1'b1;
            completed <= 1'b1;
            status    <= rrpc_pkg::ST_DONE;
          end else if (quo == '0) begin
            carry  <= rem;
            status <= rrpc_pkg::ST_NONE;
          end else begin
            playhead <= playhead + quo[TW-1:0];
            carry    <= rem;
            status   <= rrpc_pkg::ST_CHANGED;
          end
        end
        rrpc_pkg::UOP_EMIT: begin
          if (!(out_valid && out_stall)) begin
            out_valid             <= 1'b1;
            out_data.status       <= status;
            out_data.playhead_out <= playhead;
            out_data.is_paused    <= paused;
            out_data.is_completed <= completed;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (upc == rrpc_pkg::UC_DISPATCH))
    else $error("accepted item did not reach dispatch");

  a_completed_paused: assert property (@(posedge clk) disable iff (rst)
    completed |-> paused)
    else $error("completed clock not paused");

  a_carry_below_den: assert property (@(posedge clk) disable iff (rst)
    carry < speed_den)
    else $error("carried remainder not below denominator");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(upc) == rrpc_pkg::UC_EMIT))
    else $error("result raised outside emit step");

endmodule

[tb/tb_rational_rate_playhead_clock.sv]
// Self-checking testbench for the rational-rate playhead clock.
// Depends on rrpc_pkg and rational_rate_playhead_clock; needs no other files.
`timescale 1ns / 1ps

module tb_rational_rate_playhead_clock;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 64;

  // Tracks playhead state and the results still owed by the block.
  class playhead_tracker;
    logic [31:0]     dur_ms;
    logic [31:0]     pos;
    logic [15:0]     carry;
    logic [31:0]     ref_time;
    logic            paused;
    logic            done;
    logic [15:0]     rate_num;
    logic [15:0]     rate_den;
    rrpc_pkg::res_t  pending_results[$];
    int              mismatches;
    int              checked;
    int              moves;
    int              completions;

    function new();
      dur_ms = '0;
      pos = '0;
      carry = '0;
      ref_time = '0;
      paused = 1'b0;
      done = 1'b0;
      rate_num = 16'd1;
      rate_den = 16'd1;
      mismatches = 0;
      checked = 0;
      moves = 0;
      completions = 0;
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function logic [1:0] mark_done();
      pos = dur_ms;
      carry = '0;
      paused = 1'b1;
      done = 1'b1;
      return rrpc_pkg::ST_DONE;
    endfunction

    function void note_command(rrpc_pkg::cmd_t c);
      rrpc_pkg::res_t r;
      logic [1:0]     st;
      logic [31:0]    elapsed;
      logic [31:0]    tgt;
      logic [63:0]    scaled;
      logic [63:0]    adv;
      logic [63:0]    rem;
      bit             changed;
      st = rrpc_pkg::ST_NONE;
      case (c.opcode)
        rrpc_pkg::OP_TICK: begin
          if (dur_ms != 0) begin
            elapsed = c.now - ref_time;
            ref_time = c.now;
            if (!(paused || done || elapsed == 0 || rate_den == 0)) begin
              if (pos >= dur_ms) begin
                st = mark_done();
              end else begin
                scaled = 64'(elapsed) * 64'(rate_num) + 64'(carry);
                adv = scaled / 64'(rate_den);
                rem = scaled % 64'(rate_den);
                carry = rem[15:0];
                if (adv >= 64'(dur_ms - pos)) begin
                  st = mark_done();
                end else if (adv != 0) begin
                  pos = pos + adv[31:0];
                  st = rrpc_pkg::ST_CHANGED;
                end
              end
            end
          end
          if (st == rrpc_pkg::ST_CHANGED) moves++;
          if (st == rrpc_pkg::ST_DONE) completions++;
        end
        rrpc_pkg::OP_PAUSE: begin
          if (!(paused == c.pause_flag || (done && !c.pause_flag))) begin
            paused = c.pause_flag;
            ref_time = c.now;
            carry = '0;
            st = rrpc_pkg::ST_CHANGED;
          end
        end
        rrpc_pkg::OP_RESTART: begin
          changed = pos != 0 || carry != 0 || paused || done;
          pos = '0;
          carry = '0;
          paused = 1'b0;
          done = 1'b0;
          ref_time = c.now;
          st = changed ? rrpc_pkg::ST_CHANGED : rrpc_pkg::ST_NONE;
        end
        rrpc_pkg::OP_SEEK: begin
          if (dur_ms != 0) begin
            tgt = (c.seek_ms < dur_ms) ? c.seek_ms : dur_ms;
            changed = tgt != pos || !paused || done || carry != 0;
            pos = tgt;
            ref_time = c.now;
            carry = '0;
            paused = 1'b1;
            done = (tgt == dur_ms);
            st = changed ? rrpc_pkg::ST_CHANGED : rrpc_pkg::ST_NONE;
          end
        end
        rrpc_pkg::OP_SPEED: begin
          if (!(c.rate_num == 0 || c.rate_den == 0 ||
                (c.rate_num == rate_num && c.rate_den == rate_den))) begin
            rate_num = c.rate_num;
            rate_den = c.rate_den;
            ref_time = c.now;
            carry = '0;
            st = rrpc_pkg::ST_CHANGED;
          end
        end
        default: st = rrpc_pkg::ST_NONE;
      endcase
      r.status = st;
      r.playhead_out = pos;
      r.is_paused = paused;
      r.is_completed = done;
      pending_results.push_back(r);
    endfunction

    task check_result(rrpc_pkg::res_t got);
      rrpc_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing outstanding: status %0d playhead %0d",
                         got.status, got.playhead_out));
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.playhead_out !== want.playhead_out)
          report($sformatf("playhead %0d, want %0d", got.playhead_out, want.playhead_out));
        if (got.is_paused !== want.is_paused)
          report($sformatf("paused %0b, want %0b", got.is_paused, want.is_paused));
        if (got.is_completed !== want.is_completed)
          report($sformatf("completed %0b, want %0b", got.is_completed, want.is_completed));
      end
    endtask
  endclass

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  rrpc_pkg::cmd_t in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  rrpc_pkg::res_t out_data;
  logic           cfg_we = 1'b0;
  logic [31:0]    cfg_data = '0;

  playhead_tracker tracker = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [31:0] media_ms = '0;
  int          sent = 0;

  rational_rate_playhead_clock dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_data);
  end

  function automatic rrpc_pkg::cmd_t make_cmd(logic [2:0] op, logic [31:0] now, logic flag,
                                              logic [31:0] tgt, logic [15:0] num,
                                              logic [15:0] den);
    rrpc_pkg::cmd_t c;
    c.opcode = op;
    c.now = now;
    c.pause_flag = flag;
    c.seek_ms = tgt;
    c.rate_num = num;
    c.rate_den = den;
    return c;
  endfunction

  // Mostly small forward steps of time so the playhead moves and completes.
  function rrpc_pkg::cmd_t random_command();
    rrpc_pkg::cmd_t c;
    int             pick;
    c.now = '0;
    c.pause_flag = 1'($urandom_range(1));
    c.seek_ms = $urandom;
    c.rate_num = 16'($urandom);
    c.rate_den = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) media_ms = media_ms;
    else if (pick < 90) media_ms = media_ms + $urandom_range(1, 40);
    else if (pick < 97) media_ms = media_ms + $urandom_range(41, 3000);
    else media_ms = $urandom;
    c.now = media_ms;
    pick = $urandom_range(99);
    if (pick < 50) c.opcode = rrpc_pkg::OP_TICK;
    else if (pick < 60) c.opcode = rrpc_pkg::OP_PAUSE;
    else if (pick < 66) c.opcode = rrpc_pkg::OP_RESTART;
    else if (pick < 78) c.opcode = rrpc_pkg::OP_SEEK;
    else if (pick < 94) c.opcode = rrpc_pkg::OP_SPEED;
    else c.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (c.opcode == rrpc_pkg::OP_PAUSE) c.pause_flag = ($urandom_range(99) < 35);
    if (c.opcode == rrpc_pkg::OP_SEEK) begin
      pick = $urandom_range(3);
      if (pick < 2) c.seek_ms = $urandom_range(0, tracker.dur_ms);
      else if (pick == 2) c.seek_ms = tracker.dur_ms;
    end
    if (c.opcode == rrpc_pkg::OP_SPEED) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        c.rate_num = 16'($urandom_range(1, 8));
        c.rate_den = 16'($urandom_range(1, 8));
      end else if (pick == 7) begin
        c.rate_num = tracker.rate_num;
        c.rate_den = tracker.rate_den;
      end else if (pick == 8) begin
        if ($urandom_range(1)) c.rate_num = '0;
        else c.rate_den = '0;
      end
    end
    return c;
  endfunction

  task send_cmd(rrpc_pkg::cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    tracker.note_command(c);
    sent++;
  endtask

  // Register writes only once the block has drained.
  task write_duration(logic [31:0] v);
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.dur_ms = v;
  endtask

  task random_phase(logic [31:0] dur, int count, int idle_pct, int stall_pct);
    write_duration(dur);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_cmd(random_command());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero duration straight after reset
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd5, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_SEEK, 32'd6, 1'b0, 32'd3, 16'd1, 16'd1));
    send_cmd(make_cmd(OP_SPARE_HI, 32'd7, 1'b1, '1, '1, '1));
    send_cmd(make_cmd(rrpc_pkg::OP_PAUSE, 32'd8, 1'b0, '0, 16'd1, 16'd1));

    write_duration(32'd100);
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd8, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd8, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_SPEED, 32'd8, 1'b0, '0, 16'd0, 16'd5));
    send_cmd(make_cmd(rrpc_pkg::OP_SPEED, 32'd8, 1'b0, '0, 16'd5, 16'd0));
    send_cmd(make_cmd(rrpc_pkg::OP_SPEED, 32'd8, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_SPEED, 32'd8, 1'b0, '0, 16'd3, 16'd2));
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd11, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_PAUSE, 32'd12, 1'b1, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd20, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_PAUSE, 32'd20, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd70, 1'b0, '0, 16'd1, 16'd1));
    // seek beyond the end clamps and completes; resume is then refused
    send_cmd(make_cmd(rrpc_pkg::OP_SEEK, 32'd71, 1'b0, 32'hFFFF_FFFF, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_PAUSE, 32'd72, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_RESTART, 32'd80, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_RESTART, 32'd80, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_SPEED, 32'd80, 1'b0, '0, 16'hFFFF, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd81, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_RESTART, 32'd82, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_SPEED, 32'd82, 1'b0, '0, 16'd1, 16'd1));
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd132, 1'b0, '0, 16'd1, 16'd1));
    // shrink the duration under a running playhead
    write_duration(32'd20);
    send_cmd(make_cmd(rrpc_pkg::OP_TICK, 32'd140, 1'b0, '0, 16'd1, 16'd1));

    media_ms = 32'd140;
    random_phase(32'd1000, 120, 27, 55);
    random_phase(32'hFFFF_FFFF, 100, 27, 55);
    random_phase(32'd1, 60, 55, 27);
    random_phase($urandom_range(50, 5000), 120, 55, 27);
    random_phase(32'd0, 30, 0, 0);
    random_phase(32'd300, 120, 0, 0);
    random_phase($urandom, 100, 0, 0);

    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d commands, %0d results checked, %0d playhead moves, %0d completions",
             sent, tracker.checked, tracker.moves, tracker.completions);
    $display("Durations swept from zero to full range under three idle/stall mixes");
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", tracker.pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
